@@ design/ilt_pkg.sv @@
// Package: shared constants and types of the involutory Latin table checker.
package ilt_pkg;

    localparam int MAX_ELEMENTS_DEF = 8;
    localparam int FIELD_LIMIT      = 8;
    localparam int VAL_W            = 3;
    localparam int MASK_W           = 8;
    localparam int CNT_W            = 7;
    localparam int ORDER_W          = 4;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;
    localparam logic               REQ_ASSIGN  = 1'b0;
    localparam logic               REQ_CLEAR   = 1'b1;
    localparam logic               REG_ORDER   = 1'b0;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [MASK_W-1:0] t_mask;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_CAND = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

@@ design/involutory_latin_table_checker_top.sv @@
// Top level: involutory Latin table checker, table in two RAM copies, sequenced sweep.
// One word is worked on at a time; a result still held at the output stalls the next word.
// The time per word is set by the one-cell-per-cycle RAM sweep over the table, then over the
//   row and column of the first free cell, a sweep that is skipped when no cell is free.
// Reset: order 3, all marks and the count cleared at once.
module involutory_latin_table_checker_top #(
    parameter int MAX_ELEMENTS = ilt_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [2:0]                  i_row_index,
    input  logic [2:0]                  i_col_index,
    input  logic [2:0]                  i_cell_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_feasible,
    output logic                        o_complete,
    output logic                        o_valid_table,
    output logic [2:0]                  o_next_row,
    output logic [2:0]                  o_next_col,
    output logic                        o_none_unassigned,
    output logic [7:0]                  o_candidate_mask,
    output logic                        o_bad_request,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ilt_pkg::PADDR_W-1:0] paddr,
    input  logic [ilt_pkg::PDATA_W-1:0] pwdata,
    output logic [ilt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int AW    = 2 * IW;
    localparam int NADDR = 1 << AW;
    localparam int NIDX  = 1 << IW;
    localparam int LIM   = (MAX_ELEMENTS < ilt_pkg::FIELD_LIMIT) ? MAX_ELEMENTS
                                                                 : ilt_pkg::FIELD_LIMIT;
    localparam int OW    = ilt_pkg::ORDER_W;
    localparam int VW    = ilt_pkg::VAL_W;
    localparam int MW    = ilt_pkg::MASK_W;
    localparam int CW    = ilt_pkg::CNT_W;

    function automatic ilt_pkg::t_val i2v(input logic [IW-1:0] x);
        logic [IW+VW-1:0] t;
        t = {{VW{1'b0}}, x};
        return t[VW-1:0];
    endfunction

    function automatic logic [IW-1:0] v2i(input ilt_pkg::t_val x);
        logic [IW+VW-1:0] t;
        t = {{IW{1'b0}}, x};
        return t[IW-1:0];
    endfunction

    function automatic logic [OW-1:0] i2o(input logic [IW-1:0] x);
        logic [IW+OW-1:0] t;
        t = {{OW{1'b0}}, x};
        return t[OW-1:0];
    endfunction

    ilt_pkg::t_state r_state;
    logic [OW-1:0]   r_order;
    logic [NADDR-1:0] r_marks;
    logic [CW-1:0]   r_count;

    logic            r_bad;
    logic            r_iss;
    logic [IW-1:0]   r_a;
    logic [IW-1:0]   r_b;
    logic            r_s1_v;
    logic [IW-1:0]   r_s1_a;
    logic [IW-1:0]   r_s1_b;
    logic            r_s1_m;
    logic            r_s1_mb;
    logic            r_s2_v;
    logic [IW-1:0]   r_s2_a;
    logic            r_s2_chk;
    logic            r_feas;
    logic            r_found;
    logic [IW-1:0]   r_nr;
    logic [IW-1:0]   r_nc;
    ilt_pkg::t_mask  r_row_seen;
    ilt_pkg::t_mask  r_col_seen [NIDX];
    ilt_pkg::t_mask  r_rowm;
    ilt_pkg::t_mask  r_colm;
    ilt_pkg::t_mask  r_allow;

    logic            r_ov;
    logic            r_o_feas;
    logic            r_o_comp;
    logic            r_o_valid;
    ilt_pkg::t_val   r_o_nr;
    ilt_pkg::t_val   r_o_nc;
    logic            r_o_none;
    ilt_pkg::t_mask  r_o_mask;
    logic            r_o_bad;

    logic [OW-1:0]   n_eff;
    logic [OW-1:0]   n_last;
    logic            in_acc;
    logic            cfg_wr;
    logic            bad_in;
    logic            wr_cell;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    ilt_pkg::t_val   rd_a;
    ilt_pkg::t_val   rd_b;
    logic [AW-1:0]   jaddr;
    ilt_pkg::t_mask  bit_a;
    ilt_pkg::t_mask  bit_b;
    ilt_pkg::t_mask  row_base;
    ilt_pkg::t_mask  col_base;
    logic            fail1;
    ilt_pkg::t_mask  hot_a;
    ilt_pkg::t_mask  diagm;
    ilt_pkg::t_mask  nmask;
    ilt_pkg::t_mask  cand;
    logic [CW-1:0]   nn;
    logic            fin_load;

    always_comb begin
        if (r_order == '0) begin
            n_eff = OW'(1);
        end else if (r_order > OW'(LIM)) begin
            n_eff = OW'(LIM);
        end else begin
            n_eff = r_order;
        end
    end

    assign n_last  = n_eff - OW'(1);
    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign bad_in  = ({1'b0, i_row_index} >= n_eff) || ({1'b0, i_col_index} >= n_eff);
    assign wr_cell = in_acc && (i_req_type == ilt_pkg::REQ_ASSIGN) && !bad_in;
    assign waddr   = {v2i(i_row_index), v2i(i_col_index)};

    assign jaddr   = {v2i(rd_a), r_s1_b};
    assign raddr_a = (r_state == ilt_pkg::ST_CAND) ? {r_a, r_nc} : {r_a, r_b};
    assign raddr_b = (r_state == ilt_pkg::ST_CAND) ? {r_nr, r_a} : jaddr;

    assign bit_a    = MW'(1) << rd_a;
    assign bit_b    = MW'(1) << rd_b;
    assign hot_a    = MW'(1) << r_s1_a;
    assign row_base = (r_s1_b == '0) ? '0 : r_row_seen;
    assign col_base = (r_s1_a == '0) ? '0 : r_col_seen[r_s1_b];
    assign fail1    = r_s1_m && (((r_s1_a == r_s1_b) && (rd_a != i2v(r_s1_a)))
                      || ({1'b0, rd_a} >= n_eff)
                      || ((row_base & bit_a) != '0)
                      || ((col_base & bit_a) != '0));

    assign diagm    = (r_nr == r_nc) ? (MW'(1) << r_nr) : '1;
    assign nmask    = ~({MW{1'b1}} << n_eff);
    assign cand     = (r_found && r_feas) ? (r_allow & ~r_rowm & ~r_colm & diagm & nmask) : '0;
    assign nn       = CW'({3'b000, n_eff} * {3'b000, n_eff});
    assign fin_load = (r_state == ilt_pkg::ST_FIN) && (!r_ov || i_out_ready);

    ilt_ram #(.WIDTH(VW), .DEPTH(NADDR)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_cell),
        .i_waddr (waddr),
        .i_wdata (i_cell_value),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    ilt_ram #(.WIDTH(VW), .DEPTH(NADDR)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_cell),
        .i_waddr (waddr),
        .i_wdata (i_cell_value),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ilt_pkg::ST_IDLE;
            r_order  <= ilt_pkg::ORDER_RESET;
            r_marks  <= '0;
            r_count  <= '0;
            r_iss    <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && !fin_load) begin
                r_ov <= 1'b0;
            end
            if (cfg_wr && (paddr[2] == ilt_pkg::REG_ORDER)) begin
                r_order <= pwdata[OW-1:0];
                r_marks <= '0;
                r_count <= '0;
            end else if (in_acc) begin
                if (i_req_type == ilt_pkg::REQ_CLEAR) begin
                    r_marks <= '0;
                    r_count <= '0;
                end else if (wr_cell) begin
                    r_marks[waddr] <= 1'b1;
                    if (!r_marks[waddr]) begin
                        r_count <= r_count + CW'(1);
                    end
                end
            end
            case (r_state)
                ilt_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_bad      <= (i_req_type == ilt_pkg::REQ_ASSIGN) && bad_in;
                        r_iss      <= 1'b1;
                        r_a        <= '0;
                        r_b        <= '0;
                        r_feas     <= 1'b1;
                        r_found    <= 1'b0;
                        r_nr       <= '0;
                        r_nc       <= '0;
                        r_row_seen <= '0;
                        r_state    <= ilt_pkg::ST_SCAN;
                    end
                end
                ilt_pkg::ST_SCAN: begin
                    r_s1_v <= r_iss;
                    r_s1_a <= r_a;
                    r_s1_b <= r_b;
                    r_s1_m <= r_marks[{r_a, r_b}];
                    if (r_iss) begin
                        if (!r_found && !r_marks[{r_a, r_b}]) begin
                            r_found <= 1'b1;
                            r_nr    <= r_a;
                            r_nc    <= r_b;
                        end
                        if (i2o(r_b) == n_last) begin
                            r_b <= '0;
                            if (i2o(r_a) == n_last) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_a <= r_a + IW'(1);
                            end
                        end else begin
                            r_b <= r_b + IW'(1);
                        end
                    end
                    r_s2_v   <= r_s1_v;
                    r_s2_a   <= r_s1_a;
                    r_s2_chk <= r_s1_m && r_marks[jaddr];
                    if (r_s1_v) begin
                        r_row_seen         <= row_base | (r_s1_m ? bit_a : '0);
                        r_col_seen[r_s1_b] <= col_base | (r_s1_m ? bit_a : '0);
                    end
                    if ((r_s1_v && fail1)
                        || (r_s2_v && r_s2_chk && (rd_b != i2v(r_s2_a)))) begin
                        r_feas <= 1'b0;
                    end
                    if (!r_iss && !r_s1_v && !r_s2_v) begin
                        if (r_found) begin
                            r_a     <= '0;
                            r_iss   <= 1'b1;
                            r_rowm  <= '0;
                            r_colm  <= '0;
                            r_allow <= '1;
                            r_state <= ilt_pkg::ST_CAND;
                        end else begin
                            r_state <= ilt_pkg::ST_FIN;
                        end
                    end
                end
                ilt_pkg::ST_CAND: begin
                    r_s1_v  <= r_iss;
                    r_s1_a  <= r_a;
                    r_s1_m  <= r_marks[{r_a, r_nc}];
                    r_s1_mb <= r_marks[{r_nr, r_a}];
                    if (r_iss) begin
                        if (i2o(r_a) == n_last) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_a <= r_a + IW'(1);
                        end
                    end
                    if (r_s1_v) begin
                        if (r_s1_m) begin
                            r_colm  <= r_colm | bit_a;
                            r_allow <= r_allow & ((rd_a == i2v(r_nr)) ? hot_a : ~hot_a);
                        end
                        if (r_s1_mb) begin
                            r_rowm <= r_rowm | bit_b;
                        end
                    end
                    if (!r_iss && !r_s1_v) begin
                        r_state <= ilt_pkg::ST_FIN;
                    end
                end
                ilt_pkg::ST_FIN: begin
                    if (fin_load) begin
                        r_ov      <= 1'b1;
                        r_o_feas  <= r_feas;
                        r_o_comp  <= (r_count == nn);
                        r_o_valid <= (r_count == nn) && r_feas;
                        r_o_nr    <= r_found ? i2v(r_nr) : '0;
                        r_o_nc    <= r_found ? i2v(r_nc) : '0;
                        r_o_none  <= !r_found;
                        r_o_mask  <= cand;
                        r_o_bad   <= r_bad;
                        r_state   <= ilt_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ilt_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == ilt_pkg::ST_IDLE);
    assign o_out_valid       = r_ov;
    assign o_feasible        = r_o_feas;
    assign o_complete        = r_o_comp;
    assign o_valid_table     = r_o_valid;
    assign o_next_row        = r_o_nr;
    assign o_next_col        = r_o_nc;
    assign o_none_unassigned = r_o_none;
    assign o_candidate_mask  = r_o_mask;
    assign o_bad_request     = r_o_bad;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ilt_pkg::REG_ORDER)
                    ? {{(ilt_pkg::PDATA_W-OW){1'b0}}, r_order} : '0;

endmodule

@@ design/ilt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ilt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
